/* rtl/bba_pkg.sv */
//------------------------------------------------------------------------------
// bba_pkg
// Shared types and codes of the buddy block allocator: controller states,
// command and status bundles between controller and datapath, item codes.
//------------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    // Item function codes
    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FREE  = 2'd1;
    localparam logic [1:0] FUNC_COAL  = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_SPACE = 2'd1;
    localparam logic [1:0] STAT_NO_OWNER = 2'd2;
    localparam logic [1:0] STAT_NO_MERGE = 2'd3;

    // Register indexes
    localparam logic REG_TOTAL_ORDER = 1'b0;
    localparam logic REG_LAZY_MODE   = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_RD,
        ST_A_EV,
        ST_A_SPLIT,
        ST_F_RD,
        ST_F_EV,
        ST_P_INIT,
        ST_P_RD,
        ST_P_EV,
        ST_P_BEV,
        ST_M_B,
        ST_M_P,
        ST_DONE
    } bba_state_t;

    typedef enum logic {
        RD_G,
        RD_B
    } rd_sel_t;

    typedef enum logic [1:0] {
        G_HOLD,
        G_ZERO,
        G_ADV_RD,
        G_ADV_CUR
    } g_op_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_SPLIT,
        WR_ALLOC,
        WR_FREE,
        WR_MRG_B,
        WR_MRG_P,
        WR_CLR
    } wr_op_t;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_ALLOC,
        RES_FREE,
        RES_MERGE,
        RES_FAIL
    } res_op_t;

    typedef struct packed {
        rd_sel_t    rd_sel;
        g_op_t      g_op;
        wr_op_t     wr_op;
        res_op_t    res_op;
        logic [1:0] fail_status;
        logic       in_ready;
        logic       k_load;
        logic       k_dec;
        logic       cur_load;
        logic       best_clr;
        logic       best_upd;
        logic       clr_start;
        logic       out_load;
    } bba_cmd_t;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] in_func;
        logic       span_end;
        logic       fits_rd;
        logic       split_ok;
        logic       own_hit;
        logic       cand;
        logic       bud_ok;
        logic       best_valid;
        logic       clr_last;
        logic       out_free;
    } bba_stat_t;

endpackage

`default_nettype wire

/* rtl/bba_ifs.sv */
//------------------------------------------------------------------------------
// bba_in_if / bba_out_if
// Valid/ready channels carrying allocator requests and results.
//------------------------------------------------------------------------------
`default_nettype none

interface bba_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [13:0] request_kb;
    logic [15:0] owner_id;

    modport source (output valid, output func, output request_kb, output owner_id,
                    input ready);
    modport sink   (input valid, input func, input request_kb, input owner_id,
                    output ready);
endinterface

interface bba_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [12:0] block_offset_kb;
    logic [13:0] block_kb;

    modport source (output valid, output status, output block_offset_kb,
                    output block_kb, input ready);
    modport sink   (input valid, input status, input block_offset_kb,
                    input block_kb, output ready);
endinterface

`default_nettype wire

/* rtl/bba_ctrl.sv */
//------------------------------------------------------------------------------
// bba_ctrl
// Controller of the allocator: sequences granule scans, splits, frees,
// buddy searches and merges, and the pool clearing sweep.
//------------------------------------------------------------------------------
`default_nettype none

module bba_ctrl
    import bba_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      lazy,
    input  wire logic      clear_req,
    input  wire bba_stat_t stat,
    output bba_cmd_t       cmd
);

    bba_state_t state_reg, state_next;
    logic       coal_reg, coal_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            coal_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            coal_reg  <= coal_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        coal_next  = coal_reg;
        cmd        = '0;
        cmd.rd_sel = RD_G;
        cmd.g_op   = G_HOLD;
        cmd.wr_op  = WR_NONE;
        cmd.res_op = RES_NONE;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.wr_op = WR_CLR;
                // a new pool order restarts the sweep
                if (clear_req)
                    cmd.clr_start = 1'b1;
                else if (stat.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (clear_req)
                begin
                    cmd.clr_start = 1'b1;
                    state_next    = ST_CLEAR;
                end
                else
                begin
                    cmd.in_ready = 1'b1;
                    if (stat.in_valid)
                    begin
                        cmd.g_op  = G_ZERO;
                        coal_next = (stat.in_func == FUNC_COAL);
                        case (stat.in_func)
                            FUNC_ALLOC: state_next = ST_A_RD;
                            FUNC_FREE:  state_next = ST_F_RD;
                            FUNC_COAL:  state_next = ST_P_INIT;
                            default:
                            begin
                                cmd.res_op      = RES_FAIL;
                                cmd.fail_status = STAT_NO_MERGE;
                                state_next      = ST_DONE;
                            end
                        endcase
                    end
                end
            end
            // allocate: first fitting free block
            ST_A_RD:
            begin
                if (stat.span_end)
                begin
                    cmd.res_op      = RES_FAIL;
                    cmd.fail_status = STAT_NO_SPACE;
                    state_next      = ST_DONE;
                end
                else
                    state_next = ST_A_EV;
            end
            ST_A_EV:
            begin
                if (stat.fits_rd)
                begin
                    cmd.k_load = 1'b1;
                    state_next = ST_A_SPLIT;
                end
                else
                begin
                    cmd.g_op   = G_ADV_RD;
                    state_next = ST_A_RD;
                end
            end
            ST_A_SPLIT:
            begin
                if (stat.split_ok)
                begin
                    cmd.k_dec = 1'b1;
                    cmd.wr_op = WR_SPLIT;
                end
                else
                begin
                    cmd.wr_op  = WR_ALLOC;
                    cmd.res_op = RES_ALLOC;
                    state_next = ST_DONE;
                end
            end
            // free: first block held by the owner
            ST_F_RD:
            begin
                if (stat.span_end)
                begin
                    cmd.res_op      = RES_FAIL;
                    cmd.fail_status = STAT_NO_OWNER;
                    state_next      = ST_DONE;
                end
                else
                    state_next = ST_F_EV;
            end
            ST_F_EV:
            begin
                if (stat.own_hit)
                begin
                    cmd.wr_op  = WR_FREE;
                    cmd.res_op = RES_FREE;
                    state_next = lazy ? ST_DONE : ST_P_INIT;
                end
                else
                begin
                    cmd.g_op   = G_ADV_RD;
                    state_next = ST_F_RD;
                end
            end
            // buddy pair search
            ST_P_INIT:
            begin
                cmd.g_op     = G_ZERO;
                cmd.best_clr = 1'b1;
                state_next   = ST_P_RD;
            end
            ST_P_RD:
            begin
                if (stat.span_end)
                begin
                    if (stat.best_valid)
                        state_next = ST_M_B;
                    else
                    begin
                        if (coal_reg)
                        begin
                            cmd.res_op      = RES_FAIL;
                            cmd.fail_status = STAT_NO_MERGE;
                        end
                        state_next = ST_DONE;
                    end
                end
                else
                    state_next = ST_P_EV;
            end
            ST_P_EV:
            begin
                if (stat.cand)
                begin
                    cmd.cur_load = 1'b1;
                    cmd.rd_sel   = RD_B;
                    state_next   = ST_P_BEV;
                end
                else
                begin
                    cmd.g_op   = G_ADV_RD;
                    state_next = ST_P_RD;
                end
            end
            ST_P_BEV:
            begin
                cmd.best_upd = stat.bud_ok;
                cmd.g_op     = G_ADV_CUR;
                state_next   = ST_P_RD;
            end
            // merge the chosen pair
            ST_M_B:
            begin
                cmd.wr_op  = WR_MRG_B;
                state_next = ST_M_P;
            end
            ST_M_P:
            begin
                cmd.wr_op = WR_MRG_P;
                if (coal_reg)
                begin
                    cmd.res_op = RES_MERGE;
                    state_next = ST_DONE;
                end
                else
                    state_next = ST_P_INIT;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/bba_dp.sv */
//------------------------------------------------------------------------------
// bba_dp
// Datapath of the allocator: granule table memory, scan pointer, search
// registers, result and output registers.
//------------------------------------------------------------------------------
`default_nettype none

module bba_dp
    import bba_pkg::*;
#(
    parameter int MAX_GRANULES = 256,
    parameter int GRANULE_KB   = 32,
    parameter int OWNER_BITS   = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [3:0] pool_order,
    input  wire bba_cmd_t   cmd,
    output bba_stat_t       stat,
    bba_in_if.sink          in_ch,
    bba_out_if.source       out_ch
);

    localparam int AW  = $clog2(MAX_GRANULES);
    localparam int GW  = AW + 1;
    localparam int SZW = $clog2(GRANULE_KB + 1) + 16;
    localparam int OFW = GW + $clog2(GRANULE_KB + 1);
    localparam int EW  = OWNER_BITS + 6;

    // Table entry: {is_start, order, free, owner}
    logic [EW-1:0]         mem [MAX_GRANULES];
    logic [EW-1:0]         rdata_reg;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [EW-1:0]         wr_data;

    logic [GW-1:0]         g_reg, g_next;
    logic [3:0]            k_reg;
    logic [3:0]            cur_k_reg;
    logic [GW-1:0]         best_reg;
    logic [4:0]            best_k_reg;
    logic                  best_valid_reg;
    logic [AW-1:0]         clr_cnt_reg;
    logic [13:0]           req_reg;
    logic [OWNER_BITS-1:0] owner_reg;

    logic [1:0]            res_status_reg;
    logic [12:0]           res_off_reg;
    logic [13:0]           res_kb_reg;

    logic                  out_valid_reg;
    logic [1:0]            out_status_reg;
    logic [12:0]           out_off_reg;
    logic [13:0]           out_kb_reg;

    logic                  rd_start;
    logic [3:0]            rd_order;
    logic                  rd_free;
    logic [OWNER_BITS-1:0] rd_owner;
    logic [GW-1:0]         span;
    logic [GW-1:0]         step_rd;
    logic [GW-1:0]         b_rd;
    logic [GW-1:0]         b_split;
    logic [GW-1:0]         b_best;
    logic [3:0]            k_m1;
    logic [3:0]            res_k;
    logic [GW-1:0]         res_g;

    function automatic logic [SZW-1:0] size_of(input logic [3:0] k);
        size_of = SZW'(GRANULE_KB) << k;
    endfunction

    assign {rd_start, rd_order, rd_free, rd_owner} = rdata_reg;
    assign span    = GW'(1) << pool_order;
    assign step_rd = GW'(1) << rd_order;
    assign b_rd    = g_reg + step_rd;
    assign k_m1    = k_reg - 4'd1;
    assign b_split = g_reg + (GW'(1) << k_m1);
    assign b_best  = best_reg + (GW'(1) << best_k_reg[3:0]);

    // Status toward the controller
    always_comb
    begin
        stat            = '0;
        stat.in_valid   = in_ch.valid;
        stat.in_func    = in_ch.func;
        stat.span_end   = (g_reg >= span);
        stat.fits_rd    = rd_free && (size_of(rd_order) >= SZW'(req_reg));
        stat.split_ok   = (k_reg != 4'd0) && (size_of(k_m1) >= SZW'(req_reg));
        stat.own_hit    = !rd_free && (rd_owner == owner_reg);
        stat.cand       = rd_free && (rd_order < pool_order)
                          && ({1'b0, rd_order} < best_k_reg)
                          && (((g_reg >> rd_order) & GW'(1)) == '0)
                          && (b_rd < span);
        stat.bud_ok     = rd_start && rd_free && (rd_order == cur_k_reg);
        stat.best_valid = best_valid_reg;
        stat.clr_last   = &clr_cnt_reg;
        stat.out_free   = !out_valid_reg || out_ch.ready;
    end

    assign in_ch.ready = cmd.in_ready;

    // Read address
    always_comb
    begin
        case (cmd.rd_sel)
            RD_B:    rd_addr = b_rd[AW-1:0];
            default: rd_addr = g_reg[AW-1:0];
        endcase
    end

    // Write port
    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = g_reg[AW-1:0];
        wr_data = {1'b1, k_reg, 1'b1, {OWNER_BITS{1'b0}}};
        case (cmd.wr_op)
            WR_SPLIT:
            begin
                wr_addr = b_split[AW-1:0];
                wr_data = {1'b1, k_m1, 1'b1, {OWNER_BITS{1'b0}}};
            end
            WR_ALLOC:
                wr_data = {1'b1, k_reg, 1'b0, owner_reg};
            WR_FREE:
                wr_data = {rd_start, rd_order, 1'b1, {OWNER_BITS{1'b0}}};
            WR_MRG_B:
            begin
                wr_addr = b_best[AW-1:0];
                wr_data = {1'b0, 4'd0, 1'b1, {OWNER_BITS{1'b0}}};
            end
            WR_MRG_P:
            begin
                wr_addr = best_reg[AW-1:0];
                wr_data = {1'b1, best_k_reg[3:0] + 4'd1, 1'b1, {OWNER_BITS{1'b0}}};
            end
            WR_CLR:
            begin
                wr_addr = clr_cnt_reg;
                if (clr_cnt_reg == '0)
                    wr_data = {1'b1, pool_order, 1'b1, {OWNER_BITS{1'b0}}};
                else
                    wr_data = {1'b0, 4'd0, 1'b1, {OWNER_BITS{1'b0}}};
            end
            default:
                wr_en = 1'b0;
        endcase
    end

    // Granule table
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    // Scan pointer
    always_comb
    begin
        case (cmd.g_op)
            G_ZERO:    g_next = '0;
            G_ADV_RD:  g_next = g_reg + step_rd;
            G_ADV_CUR: g_next = g_reg + (GW'(1) << cur_k_reg);
            default:   g_next = g_reg;
        endcase
    end

    // Result fields
    always_comb
    begin
        res_g = g_reg;
        res_k = k_reg;
        case (cmd.res_op)
            RES_FREE:  res_k = rd_order;
            RES_MERGE:
            begin
                res_g = best_reg;
                res_k = best_k_reg[3:0] + 4'd1;
            end
            default:   res_k = k_reg;
        endcase
    end

    // Search and item registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg    <= '0;
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clr_start)
                clr_cnt_reg <= '0;
            else if (cmd.wr_op == WR_CLR)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (cmd.best_clr)
                best_valid_reg <= 1'b0;
            else if (cmd.best_upd)
                best_valid_reg <= 1'b1;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg <= g_next;
        if (in_ch.valid && cmd.in_ready)
        begin
            req_reg   <= in_ch.request_kb;
            owner_reg <= OWNER_BITS'(in_ch.owner_id);
        end
        if (cmd.k_load)
            k_reg <= rd_order;
        else if (cmd.k_dec)
            k_reg <= k_m1;
        if (cmd.cur_load)
            cur_k_reg <= rd_order;
        if (cmd.best_clr)
            best_k_reg <= 5'd16;
        else if (cmd.best_upd)
        begin
            best_reg   <= g_reg;
            best_k_reg <= {1'b0, cur_k_reg};
        end
        case (cmd.res_op)
            RES_ALLOC, RES_FREE, RES_MERGE:
            begin
                res_status_reg <= STAT_OK;
                res_off_reg    <= 13'(OFW'(res_g) * OFW'(GRANULE_KB));
                res_kb_reg     <= 14'(size_of(res_k));
            end
            RES_FAIL:
            begin
                res_status_reg <= cmd.fail_status;
                res_off_reg    <= '0;
                res_kb_reg     <= '0;
            end
            default:
            begin
                res_status_reg <= res_status_reg;
            end
        endcase
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_off_reg    <= res_off_reg;
            out_kb_reg     <= res_kb_reg;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.status          = out_status_reg;
    assign out_ch.block_offset_kb = out_off_reg;
    assign out_ch.block_kb        = out_kb_reg;

endmodule

`default_nettype wire

/* rtl/buddy_block_allocator_core.sv */
//------------------------------------------------------------------------------
// buddy_block_allocator_core
// Buddy allocator over a power-of-two pool of granules with an APB config port.
//------------------------------------------------------------------------------
// Usage: requests enter on in_ch (func, request_kb, owner_id) and one result
// per request leaves on out_ch (status, block_offset_kb, block_kb); a transfer
// happens when valid and ready are both high. One request is worked at a time.
// The granule table is a single-port-write memory read one entry per visit:
// each block visited in a scan is read and then evaluated, a buddy check adds
// a read of the buddy entry and its evaluation, a split writes the upper half,
// and a merge writes the buddy and then the parent. An allocate splits the
// found block as far as the request allows; an eager free adds one full pair
// search per merge done, and a last search that finds no pair.
// Reset, or a total_order write taken while idle or clearing, starts a sweep
// of the table that rebuilds the pool as one free block; in_ch.ready
// stays low during it. Results sit in an output register: a stalled receiver
// holds the result while the next request is still taken and worked, and
// that request then waits to finish until the register frees.
// Registers: total_order at 0x0, lazy_mode at 0x4 (address bit 2 decodes).
//------------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator_core
    import bba_pkg::*;
#(
    parameter int MAX_GRANULES = 256,
    parameter int GRANULE_KB   = 32,
    parameter int OWNER_BITS   = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    bba_in_if.sink           in_ch,
    bba_out_if.source        out_ch
);

    localparam int         AW  = $clog2(MAX_GRANULES);
    localparam logic [3:0] AW4 = 4'(AW);

    logic [3:0] total_order_reg;
    logic       lazy_mode_reg;
    logic       clear_req_reg;
    logic       wr_stb;
    logic [3:0] pool_order;
    bba_cmd_t   cmd;
    bba_stat_t  stat;

    // Config register writes
    assign pready = 1'b1;
    assign wr_stb = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_order_reg <= 4'd8;
            lazy_mode_reg   <= 1'b0;
            clear_req_reg   <= 1'b0;
        end
        else
        begin
            clear_req_reg <= 1'b0;
            if (wr_stb)
            begin
                case (paddr[2])
                    REG_TOTAL_ORDER:
                    begin
                        total_order_reg <= pwdata[3:0];
                        clear_req_reg   <= 1'b1;
                    end
                    default:
                        lazy_mode_reg <= pwdata[0];
                endcase
            end
        end
    end

    // Register readback
    always_comb
    begin
        case (paddr[2])
            REG_TOTAL_ORDER: prdata = {28'd0, total_order_reg};
            default:         prdata = {31'd0, lazy_mode_reg};
        endcase
    end

    // Pool order saturates at the table size
    assign pool_order = (total_order_reg > AW4) ? AW4 : total_order_reg;

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .lazy      (lazy_mode_reg),
        .clear_req (clear_req_reg),
        .stat      (stat),
        .cmd       (cmd)
    );

    bba_dp #(
        .MAX_GRANULES (MAX_GRANULES),
        .GRANULE_KB   (GRANULE_KB),
        .OWNER_BITS   (OWNER_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .pool_order (pool_order),
        .cmd        (cmd),
        .stat       (stat),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire
